/* hdl/sti_pkg.sv */
// package for the sorted table insert/remove block
// holds sizes, status codes, state encoding and controller/datapath command types
// no dependencies
`default_nettype none

package sti_pkg;

    localparam int CAPACITY    = 16;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 5;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_INS_PUT,
        S_REM_SCAN,
        S_REM_SHIFT,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LOAD_CNT,
        IDX_LOAD_ZERO,
        IDX_INC,
        IDX_DEC
    } idx_cmd_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_CNT_M1,
        RD_IDX_M2,
        RD_IDX_P1,
        RD_IDX_P2,
        RD_ZERO
    } rd_cmd_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_RDATA_AT_IDX,
        WR_VAL_AT_IDX
    } wr_cmd_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_cmd_t;

    typedef struct packed {
        logic     load_req;
        idx_cmd_t idx_cmd;
        rd_cmd_t  rd_cmd;
        wr_cmd_t  wr_cmd;
        cnt_cmd_t cnt_cmd;
        logic     load_res;
        status_t  res_status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic gt;
        logic eq;
        logic idx_is_one;
        logic last_scan;
        logic last_shift;
        logic res_free;
    } sts_t;

endpackage

`default_nettype wire

/* hdl/sti_ram.sv */
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module sti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* hdl/sti_datapath.sv */
// datapath: entry ram, position counter, entry count, smallest value shadow, result register
// depends on sti_pkg and sti_ram
`default_nettype none

module sti_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sti_pkg::cmd_t                       cmd,
    output sti_pkg::sts_t                            sts,
    input  wire logic signed [sti_pkg::DATA_W-1:0]   value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [1:0]                   status,
    output logic             [sti_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic signed      [sti_pkg::DATA_W-1:0]   smallest_value,
    output logic                                     is_empty
);

    localparam int CW = sti_pkg::CNT_W;
    localparam int AW = sti_pkg::ADDR_W;
    localparam int DW = sti_pkg::DATA_W;

    logic signed [DW-1:0] val_reg;
    logic        [CW-1:0] idx_reg, idx_next;
    logic        [CW-1:0] cnt_reg, cnt_next;
    logic        [DW-1:0] small_reg;

    logic                  res_valid_reg, res_valid_next;
    sti_pkg::status_t      res_status_reg;
    logic [sti_pkg::COUNT_OUT_W-1:0] res_count_reg;
    logic        [DW-1:0]  res_small_reg;
    logic                  res_empty_reg;

    logic          rd_en;
    logic [AW-1:0] rd_pos;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;
    logic [CW:0]   idx_p1, idx_p2;

    sti_ram #(
        .WIDTH (DW),
        .DEPTH (sti_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_pos),
        .rd_data (rd_data)
    );

    assign idx_p1 = (CW+1)'(idx_reg) + (CW+1)'(1);
    assign idx_p2 = (CW+1)'(idx_reg) + (CW+1)'(2);

    // read address select
    always_comb
    begin
        rd_en  = 1'b1;
        rd_pos = '0;
        unique case (cmd.rd_cmd)
            sti_pkg::RD_NONE:   rd_en  = 1'b0;
            sti_pkg::RD_CNT_M1: rd_pos = AW'(cnt_reg - CW'(1));
            sti_pkg::RD_IDX_M2: rd_pos = AW'(idx_reg - CW'(2));
            sti_pkg::RD_IDX_P1: rd_pos = idx_p1[AW-1:0];
            sti_pkg::RD_IDX_P2: rd_pos = idx_p2[AW-1:0];
            sti_pkg::RD_ZERO:   rd_pos = '0;
            default:            rd_en  = 1'b0;
        endcase
    end

    // write select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[AW-1:0];
        wr_data = rd_data;
        unique case (cmd.wr_cmd)
            sti_pkg::WR_NONE:         wr_en = 1'b0;
            sti_pkg::WR_RDATA_AT_IDX: wr_en = 1'b1;
            sti_pkg::WR_VAL_AT_IDX:
            begin
                wr_en   = 1'b1;
                wr_data = val_reg;
            end
            default:                  wr_en = 1'b0;
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        unique case (cmd.idx_cmd)
            sti_pkg::IDX_HOLD:      idx_next = idx_reg;
            sti_pkg::IDX_LOAD_CNT:  idx_next = cnt_reg;
            sti_pkg::IDX_LOAD_ZERO: idx_next = '0;
            sti_pkg::IDX_INC:       idx_next = idx_reg + CW'(1);
            sti_pkg::IDX_DEC:       idx_next = idx_reg - CW'(1);
            default:                idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        unique case (cmd.cnt_cmd)
            sti_pkg::CNT_HOLD: cnt_next = cnt_reg;
            sti_pkg::CNT_INC:  cnt_next = cnt_reg + CW'(1);
            sti_pkg::CNT_DEC:  cnt_next = cnt_reg - CW'(1);
            default:           cnt_next = cnt_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.load_res)
        begin
            res_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            val_reg <= value;
        end
        // shadow copy of entry zero
        if (wr_en && (wr_addr == '0))
        begin
            small_reg <= wr_data;
        end
        if (cmd.load_res)
        begin
            res_status_reg <= cmd.res_status;
            res_count_reg  <= sti_pkg::COUNT_OUT_W'(cnt_reg);
            res_small_reg  <= (cnt_reg == '0) ? '0 : small_reg;
            res_empty_reg  <= (cnt_reg == '0);
        end
    end

    assign sts.full       = (cnt_reg == CW'(sti_pkg::CAPACITY));
    assign sts.empty      = (cnt_reg == '0);
    assign sts.gt         = ($signed(rd_data) > val_reg);
    assign sts.eq         = ($signed(rd_data) == val_reg);
    assign sts.idx_is_one = (idx_reg == CW'(1));
    assign sts.last_scan  = (idx_p1 == (CW+1)'(cnt_reg));
    assign sts.last_shift = (idx_p2 == (CW+1)'(cnt_reg));
    assign sts.res_free   = !res_valid_reg || !out_stall;

    assign out_valid      = res_valid_reg;
    assign status         = res_status_reg;
    assign entry_count    = res_count_reg;
    assign smallest_value = res_small_reg;
    assign is_empty       = res_empty_reg;

endmodule

`default_nettype wire

/* hdl/sti_controller.sv */
// controller state machine: sequences insert scans, remove scans and shifts
// depends on sti_pkg
`default_nettype none

module sti_controller (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          mode,
    input  wire sti_pkg::sts_t sts,
    output sti_pkg::cmd_t      cmd
);

    sti_pkg::state_t  state_reg, state_next;
    sti_pkg::status_t stat_reg, stat_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sti_pkg::S_IDLE;
            stat_reg  <= sti_pkg::ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            stat_reg  <= stat_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        in_stall       = 1'b1;
        cmd.load_req   = 1'b0;
        cmd.idx_cmd    = sti_pkg::IDX_HOLD;
        cmd.rd_cmd     = sti_pkg::RD_NONE;
        cmd.wr_cmd     = sti_pkg::WR_NONE;
        cmd.cnt_cmd    = sti_pkg::CNT_HOLD;
        cmd.load_res   = 1'b0;
        cmd.res_status = stat_reg;

        unique case (state_reg)
            sti_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    stat_next    = sti_pkg::ST_DONE;
                    if (!mode)
                    begin
                        if (sts.full)
                        begin
                            stat_next  = sti_pkg::ST_FULL;
                            state_next = sti_pkg::S_FIN;
                        end
                        else if (sts.empty)
                        begin
                            cmd.idx_cmd = sti_pkg::IDX_LOAD_CNT;
                            state_next  = sti_pkg::S_INS_PUT;
                        end
                        else
                        begin
                            cmd.idx_cmd = sti_pkg::IDX_LOAD_CNT;
                            cmd.rd_cmd  = sti_pkg::RD_CNT_M1;
                            state_next  = sti_pkg::S_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (sts.empty)
                        begin
                            stat_next  = sti_pkg::ST_NOT_FOUND;
                            state_next = sti_pkg::S_FIN;
                        end
                        else
                        begin
                            cmd.idx_cmd = sti_pkg::IDX_LOAD_ZERO;
                            cmd.rd_cmd  = sti_pkg::RD_ZERO;
                            state_next  = sti_pkg::S_REM_SCAN;
                        end
                    end
                end
            end

            // move larger entries up one slot from the top
            sti_pkg::S_INS_CMP:
            begin
                if (sts.gt)
                begin
                    cmd.wr_cmd  = sti_pkg::WR_RDATA_AT_IDX;
                    cmd.idx_cmd = sti_pkg::IDX_DEC;
                    if (sts.idx_is_one)
                    begin
                        state_next = sti_pkg::S_INS_PUT;
                    end
                    else
                    begin
                        cmd.rd_cmd = sti_pkg::RD_IDX_M2;
                    end
                end
                else
                begin
                    cmd.wr_cmd  = sti_pkg::WR_VAL_AT_IDX;
                    cmd.cnt_cmd = sti_pkg::CNT_INC;
                    state_next  = sti_pkg::S_FIN;
                end
            end

            sti_pkg::S_INS_PUT:
            begin
                cmd.wr_cmd  = sti_pkg::WR_VAL_AT_IDX;
                cmd.cnt_cmd = sti_pkg::CNT_INC;
                state_next  = sti_pkg::S_FIN;
            end

            sti_pkg::S_REM_SCAN:
            begin
                if (sts.eq)
                begin
                    if (sts.last_scan)
                    begin
                        cmd.cnt_cmd = sti_pkg::CNT_DEC;
                        state_next  = sti_pkg::S_FIN;
                    end
                    else
                    begin
                        cmd.rd_cmd = sti_pkg::RD_IDX_P1;
                        state_next = sti_pkg::S_REM_SHIFT;
                    end
                end
                else if (sts.last_scan)
                begin
                    stat_next  = sti_pkg::ST_NOT_FOUND;
                    state_next = sti_pkg::S_FIN;
                end
                else
                begin
                    cmd.idx_cmd = sti_pkg::IDX_INC;
                    cmd.rd_cmd  = sti_pkg::RD_IDX_P1;
                end
            end

            // close the gap one slot at a time
            sti_pkg::S_REM_SHIFT:
            begin
                cmd.wr_cmd = sti_pkg::WR_RDATA_AT_IDX;
                if (sts.last_shift)
                begin
                    cmd.cnt_cmd = sti_pkg::CNT_DEC;
                    state_next  = sti_pkg::S_FIN;
                end
                else
                begin
                    cmd.idx_cmd = sti_pkg::IDX_INC;
                    cmd.rd_cmd  = sti_pkg::RD_IDX_P2;
                end
            end

            sti_pkg::S_FIN:
            begin
                if (sts.res_free)
                begin
                    cmd.load_res = 1'b1;
                    state_next   = sti_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sti_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hdl/sorted_table_insert_remove.sv */
// Sorted table of up to CAPACITY signed 32-bit values kept in ascending order
// in a single-port-read ram. An insert walks down from the top entry, moving
// each larger entry up one slot, and writes the new value into the gap; an
// insert into a full table goes straight to the finish state with a full
// status. A remove scans up from entry zero to the first match and then
// closes the gap one entry per cycle. At most one entry is read and one
// written per cycle. A new request is taken only once the previous one has
// reached the result register; a held result blocks it until it is taken.
// Top level: instantiates sti_controller and sti_datapath, depends on sti_pkg
`default_nettype none

module sorted_table_insert_remove (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  mode,
    input  wire logic signed [sti_pkg::DATA_W-1:0]     value,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic             [1:0]                     status,
    output logic             [sti_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic signed      [sti_pkg::DATA_W-1:0]     smallest_value,
    output logic                                       is_empty
);

    sti_pkg::cmd_t cmd;
    sti_pkg::sts_t sts;

    sti_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .mode     (mode),
        .sts      (sts),
        .cmd      (cmd)
    );

    sti_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_count    (entry_count),
        .smallest_value (smallest_value),
        .is_empty       (is_empty)
    );

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one still in progress");

    a_empty_smallest_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> (smallest_value == '0) && (entry_count == '0))
        else $error("empty table reports stored value or nonzero count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == sti_pkg::ST_FULL) |->
            (entry_count == sti_pkg::COUNT_OUT_W'(sti_pkg::CAPACITY)) && !is_empty)
        else $error("full status with count below capacity");

endmodule

`default_nettype wire

/* dv/tb_sorted_table_insert_remove.sv */
// testbench for sorted_table_insert_remove: random insert/remove requests, shadow table check
// driver and monitor are clocked always blocks; depends on sti_pkg and the block's rtl
`timescale 1ns / 100ps

module tb_sorted_table_insert_remove;

    localparam bit          MODE_INSERT  = 1'b0;
    localparam bit          MODE_REMOVE  = 1'b1;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          QUIET_LIMIT  = 4000;
    localparam int          PHASE_ITEMS  = 365;
    localparam int          POOL_SIZE    = 6;
    localparam logic signed [sti_pkg::DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [sti_pkg::DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    typedef enum int {
        PH_NONE,
        PH_SEND,
        PH_RECV,
        PH_BOTH,
        PH_HOLD
    } idle_phase_t;

    typedef struct {
        bit                                 mode;
        logic signed [sti_pkg::DATA_W-1:0]  value;
    } table_request_t;

    typedef struct {
        sti_pkg::status_t                   status;
        logic [sti_pkg::COUNT_OUT_W-1:0]    count;
        logic signed [sti_pkg::DATA_W-1:0]  smallest;
        logic                               empty;
    } table_answer_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_stall;
    logic                                   mode = 1'b0;
    logic signed [sti_pkg::DATA_W-1:0]      value = '0;
    logic                                   out_valid;
    logic                                   out_stall = 1'b0;
    logic [1:0]                             status;
    logic [sti_pkg::COUNT_OUT_W-1:0]        entry_count;
    logic signed [sti_pkg::DATA_W-1:0]      smallest_value;
    logic                                   is_empty;

    table_request_t                         request_q[$];
    table_answer_t                          table_answers_q[$];
    logic signed [sti_pkg::DATA_W-1:0]      shadow_table[sti_pkg::CAPACITY];
    int                                     shadow_count = 0;
    logic signed [sti_pkg::DATA_W-1:0]      value_pool[POOL_SIZE];

    idle_phase_t                   phase = PH_NONE;
    bit                            request_taken = 1'b0;
    int                            requests_queued = 0;
    int                            requests_accepted = 0;
    int                            answers_checked = 0;
    int                            error_count = 0;
    int                            quiet_cycles = 0;
    int                            hold_left = 0;
    bit                            hold_served = 1'b0;

    int                            inserts_done = 0;
    int                            full_refusals = 0;
    int                            removes_done = 0;
    int                            remove_misses = 0;
    int                            times_full = 0;
    int                            times_emptied = 0;

    sorted_table_insert_remove dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_count    (entry_count),
        .smallest_value (smallest_value),
        .is_empty       (is_empty)
    );

    always #4 clk = ~clk;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic bit roll(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic int sender_idle_pct(input idle_phase_t p);
        case (p)
            PH_SEND: return 77;
            PH_BOTH: return 17;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct(input idle_phase_t p);
        case (p)
            PH_RECV: return 77;
            PH_BOTH: return 17;
            default: return 0;
        endcase
    endfunction

    // shadow table update and expected answer for one accepted request
    task automatic update_shadow_table(input bit req_mode,
                                       input logic signed [sti_pkg::DATA_W-1:0] v);
        table_answer_t ans;
        int            pos;
        pos = 0;
        if (req_mode == MODE_INSERT)
        begin
            if (shadow_count >= sti_pkg::CAPACITY)
            begin
                ans.status = sti_pkg::ST_FULL;
                full_refusals++;
            end
            else
            begin
                while (pos < shadow_count && shadow_table[pos] <= v)
                    pos++;
                for (int i = shadow_count; i > pos; i--)
                    shadow_table[i] = shadow_table[i-1];
                shadow_table[pos] = v;
                shadow_count++;
                ans.status = sti_pkg::ST_DONE;
                inserts_done++;
                if (shadow_count == sti_pkg::CAPACITY)
                    times_full++;
            end
        end
        else
        begin
            while (pos < shadow_count && shadow_table[pos] != v)
                pos++;
            if (pos >= shadow_count)
            begin
                ans.status = sti_pkg::ST_NOT_FOUND;
                remove_misses++;
            end
            else
            begin
                for (int i = pos; i + 1 < shadow_count; i++)
                    shadow_table[i] = shadow_table[i+1];
                shadow_count--;
                ans.status = sti_pkg::ST_DONE;
                removes_done++;
                if (shadow_count == 0)
                    times_emptied++;
            end
        end
        ans.count    = shadow_count[sti_pkg::COUNT_OUT_W-1:0];
        ans.smallest = (shadow_count > 0) ? shadow_table[0] : '0;
        ans.empty    = (shadow_count == 0);
        table_answers_q.push_back(ans);
    endtask

    task automatic queue_request(input bit req_mode,
                                 input logic signed [sti_pkg::DATA_W-1:0] v);
        table_request_t req;
        req.mode  = req_mode;
        req.value = v;
        request_q.push_back(req);
        requests_queued++;
    endtask

    function automatic logic signed [sti_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(99, 0);
        if (r < 72)
            return value_pool[$urandom_range(POOL_SIZE-1, 0)];
        else if (r < 76)
            return roll(50) ? VALUE_MIN : VALUE_MAX;
        else
            return $urandom();
    endfunction

    task automatic refresh_value_pool();
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();
        value_pool[1] = value_pool[0] + 1;
        if (roll(40))
            value_pool[2] = VALUE_MIN;
        if (roll(40))
            value_pool[3] = VALUE_MAX;
    endtask

    // alternating bursts that fill and drain the table, with some plain noise
    task automatic queue_random_phase(input int count);
        int  burst_len;
        int  insert_pct;
        bit  filling;
        filling = 1'b1;
        refresh_value_pool();
        while (count > 0)
        begin
            burst_len = $urandom_range(32, 14);
            if (roll(12))
                insert_pct = 50;
            else
                insert_pct = filling ? 85 : 15;
            for (int i = 0; i < burst_len && count > 0; i++)
            begin
                if (insert_pct == 50)
                    queue_request(roll(50) ? MODE_INSERT : MODE_REMOVE, $urandom());
                else
                    queue_request(roll(insert_pct) ? MODE_INSERT : MODE_REMOVE, pick_value());
                count--;
            end
            filling = ~filling;
        end
    endtask

    task automatic wait_for_drain();
        while (requests_accepted != requests_queued || table_answers_q.size() != 0)
            @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || request_taken)
            begin
                if (request_q.size() != 0 && !roll(sender_idle_pct(phase)))
                begin
                    in_valid <= 1'b1;
                    mode     <= request_q[0].mode;
                    value    <= request_q[0].value;
                    void'(request_q.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result receiver, with one long hold-off in the pressure phase
    always @(negedge clk)
    begin
        if (phase == PH_HOLD && !hold_served)
        begin
            hold_served = 1'b1;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= roll(receiver_stall_pct(phase));
        end
    end

    // monitor, prediction and watchdog
    always @(posedge clk)
    begin
        table_answer_t want;
        bit            out_taken;
        if (rst_n)
        begin
            request_taken = in_valid && !in_stall;
            out_taken     = out_valid && !out_stall;
            if (request_taken)
            begin
                update_shadow_table(mode, value);
                requests_accepted++;
            end
            if (out_taken)
            begin
                if (table_answers_q.size() == 0)
                begin
                    report_error($sformatf("unexpected result status=%0d count=%0d",
                                           status, entry_count));
                end
                else
                begin
                    want = table_answers_q.pop_front();
                    answers_checked++;
                    if (status !== want.status)
                        report_error($sformatf("result %0d: status %0d, expected %0d",
                                               answers_checked, status, want.status));
                    if (entry_count !== want.count)
                        report_error($sformatf("result %0d: entry_count %0d, expected %0d",
                                               answers_checked, entry_count, want.count));
                    if (smallest_value !== want.smallest)
                        report_error($sformatf("result %0d: smallest_value %0d, expected %0d",
                                               answers_checked, smallest_value, want.smallest));
                    if (is_empty !== want.empty)
                        report_error($sformatf("result %0d: is_empty %0b, expected %0b",
                                               answers_checked, is_empty, want.empty));
                end
            end
            if (request_taken || out_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         quiet_cycles, table_answers_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty table, extremes, duplicates, missing value, full table
        phase = PH_NONE;
        queue_request(MODE_REMOVE, 0);
        queue_request(MODE_INSERT, 0);
        queue_request(MODE_REMOVE, 0);
        queue_request(MODE_INSERT, VALUE_MAX);
        queue_request(MODE_INSERT, VALUE_MIN);
        queue_request(MODE_INSERT, -1);
        queue_request(MODE_INSERT, -1);
        queue_request(MODE_INSERT, 1);
        queue_request(MODE_REMOVE, -1);
        queue_request(MODE_REMOVE, 32'sh5a5a_a5a5);
        for (int i = 1; i <= 12; i++)
            queue_request(MODE_INSERT, (i % 2) ? -(i * 32'sh0123_4567) : i * 32'sh0765_4321);
        queue_request(MODE_INSERT, 7);
        queue_request(MODE_REMOVE, VALUE_MIN);
        queue_request(MODE_REMOVE, VALUE_MAX);
        wait_for_drain();

        phase = PH_NONE;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        phase = PH_SEND;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        phase = PH_RECV;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        phase = PH_BOTH;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();
        phase = PH_HOLD;
        queue_random_phase(PHASE_ITEMS);
        wait_for_drain();

        phase = PH_NONE;
        repeat (40) @(posedge clk);
        if (table_answers_q.size() != 0)
            report_error($sformatf("%0d results never arrived", table_answers_q.size()));

        $display("covered %0d requests: %0d inserts, %0d refused as full, %0d removes, %0d misses",
                 requests_accepted, inserts_done, full_refusals, removes_done, remove_misses);
        $display("table filled %0d times and emptied %0d times, %0d errors",
                 times_full, times_emptied, error_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
